// File: rtl/vn3_pkg.sv
// shared constants for the 3d value noise pipeline
// no dependencies
`timescale 1ns / 1ps
package vn3_pkg;
  localparam int          DEF_FRAC_BITS = 16;
  localparam logic [31:0] K_SEED        = 32'h9e3779b9;
  localparam logic [31:0] K_X           = 32'h85ebca6b;
  localparam logic [31:0] K_Y           = 32'hc2b2ae35;
  localparam logic [31:0] K_Z           = 32'h27d4eb2f;
  localparam logic [31:0] K_MIX1        = 32'h7feb352d;
  localparam logic [31:0] K_MIX2        = 32'h846ca68b;
  localparam int          FADE_W        = 16;
  localparam int          UNIT_W        = 24;
endpackage

// File: rtl/vn3_mix.sv
// four-stage 32-bit integer mixer, top 24 bits out
// depends on vn3_pkg
`timescale 1ns / 1ps
module vn3_mix (
  input  logic                        clk,
  input  logic                        en,
  input  logic [31:0]                 h,
  output logic [vn3_pkg::UNIT_W-1:0]  unit
);
  logic [31:0] t;
  logic [31:0] m1;
  logic [31:0] m2;
  logic [31:0] m1x;
  logic [31:0] m2x;

  assign m1x = m1 ^ (m1 >> 15);
  assign m2x = m2 ^ (m2 >> 16);

  always_ff @(posedge clk) begin
    if (en) begin
      t    <= h ^ (h >> 16);
      m1   <= t * vn3_pkg::K_MIX1;
      m2   <= m1x * vn3_pkg::K_MIX2;
      unit <= m2x[31:8];
    end
  end
endmodule

// File: rtl/vn3_fade.sv
// three-stage quintic fade 6t^5-15t^4+10t^3 in q0.16
// depends on vn3_pkg
`timescale 1ns / 1ps
module vn3_fade (
  input  logic                        clk,
  input  logic                        en,
  input  logic [15:0]                 f,
  output logic [vn3_pkg::FADE_W-1:0]  fade
);
  logic [15:0] f2;
  logic [31:0] ff;
  logic [31:0] g1;
  logic [20:0] q;
  logic [36:0] p;
  logic [36:0] gq;

  // always positive, fits 37 bits
  assign p  = 37'd6 * {5'd0, ff} + (37'd10 << 32) - ((37'd15 * {21'd0, f2}) << 16);
  assign gq = {21'd0, g1[31:16]} * {16'd0, q};

  always_ff @(posedge clk) begin
    if (en) begin
      ff   <= f * f;
      f2   <= f;
      g1   <= {16'd0, ff[31:16]} * {16'd0, f2};
      q    <= p[36:16];
      fade <= (gq[36:32] != 5'd0) ? 16'hffff : gq[31:16];
    end
  end
endmodule

// File: rtl/vn3_lerp.sv
// one registered linear blend of two q0.24 values by a q0.16 weight
// depends on vn3_pkg
`timescale 1ns / 1ps
module vn3_lerp (
  input  logic                        clk,
  input  logic                        en,
  input  logic [vn3_pkg::UNIT_W-1:0]  a,
  input  logic [vn3_pkg::UNIT_W-1:0]  b,
  input  logic [vn3_pkg::FADE_W-1:0]  t,
  output logic [vn3_pkg::UNIT_W-1:0]  y
);
  logic [16:0] wa;
  logic [41:0] s;

  assign wa = 17'h10000 - {1'b0, t};
  assign s  = {18'd0, a} * {25'd0, wa} + {18'd0, b} * {26'd0, t};

  always_ff @(posedge clk) begin
    if (en) begin
      y <= s[16 +: vn3_pkg::UNIT_W];
    end
  end
endmodule

// File: rtl/value_noise_3d.sv
// top level of the seeded 3d value noise pipeline
// depends on vn3_pkg, vn3_fade, vn3_mix, vn3_lerp
`timescale 1ns / 1ps
// Seeded 3d value noise. A request carries three signed fixed-point
// coordinates with FRAC_BITS fraction bits; the block returns one signed
// q1.15 sample per request. The pipeline is nine register stages deep and
// takes a new point every cycle unless stalled; the first stage loads at the
// accepting edge. Stall from the output side freezes the whole pipe, and
// s_tready falls only while the last stage holds a result that is not being
// taken. The user writes the seed through noise_seed_we / noise_seed_wdata only
// while the pipe is empty; the block does not enforce it. z = 0 gives 2d noise.
module value_noise_3d #(
  parameter int FRAC_BITS = vn3_pkg::DEF_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,      // x_coord, y_coord, z_coord
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,      // noise_value
  input  logic        noise_seed_we,
  input  logic [31:0] noise_seed_wdata
);
  localparam int NSTG = 9;

  logic [31:0]       seed;
  logic [NSTG-1:0]   vld;
  logic              en;

  // stage 1: lattice cells and q0.16 fractions
  logic [31:0] cell_in [3];
  logic [15:0] frac_in [3];
  logic [31:0] c0 [3];
  logic [31:0] c1 [3];
  logic [15:0] fr [3];

  // stage 2: per-axis corner products
  logic [31:0] p0 [3];
  logic [31:0] p1 [3];
  logic [31:0] sp;
  logic [31:0] hsh [8];

  logic [15:0] fade4 [3];
  logic [15:0] tx5, tx6;
  logic [15:0] ty5, ty6, ty7;
  logic [15:0] tz5, tz6, tz7, tz8;

  logic [23:0] unit [8];
  logic [23:0] xl [4];
  logic [23:0] yl [2];
  logic [23:0] u;

  // whole pipe moves unless the output is held
  assign en       = !vld[NSTG-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[NSTG-1];
  assign m_tdata  = {~u[23], u[22:8]};

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
      vld  <= '0;
    end else begin
      if (noise_seed_we) begin
        seed <= noise_seed_wdata;
      end
      if (en) begin
        vld <= {vld[NSTG-2:0], s_tvalid};
      end
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_axis
    // arithmetic shift floors, negative integers included
    assign cell_in[a] = 32'($signed(s_tdata[32*a +: 32]) >>> FRAC_BITS);
    if (FRAC_BITS >= 16) begin : g_down
      assign frac_in[a] = s_tdata[32*a + FRAC_BITS - 16 +: 16];
    end else begin : g_up
      assign frac_in[a] = {s_tdata[32*a +: FRAC_BITS], {(16-FRAC_BITS){1'b0}}};
    end

    vn3_fade u_fade (.clk(clk), .en(en), .f(fr[a]), .fade(fade4[a]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        c0[a] <= cell_in[a];
        c1[a] <= cell_in[a] + 32'd1;   // wraps at the top of the range
        fr[a] <= frac_in[a];
      end
      p0[0] <= c0[0] * vn3_pkg::K_X;
      p1[0] <= c1[0] * vn3_pkg::K_X;
      p0[1] <= c0[1] * vn3_pkg::K_Y;
      p1[1] <= c1[1] * vn3_pkg::K_Y;
      p0[2] <= c0[2] * vn3_pkg::K_Z;
      p1[2] <= c1[2] * vn3_pkg::K_Z;
      sp    <= seed * vn3_pkg::K_SEED;
      // align fade weights with the lerp stages
      tx5 <= fade4[0];
      tx6 <= tx5;
      ty5 <= fade4[1];
      ty6 <= ty5;
      ty7 <= ty6;
      tz5 <= fade4[2];
      tz6 <= tz5;
      tz7 <= tz6;
      tz8 <= tz7;
    end
  end

  // corner k picks +1 on x, y, z from bits 0, 1, 2
  for (genvar k = 0; k < 8; k++) begin : g_corner
    assign hsh[k] = sp ^ (((k & 1) != 0) ? p1[0] : p0[0])
                       ^ (((k & 2) != 0) ? p1[1] : p0[1])
                       ^ (((k & 4) != 0) ? p1[2] : p0[2]);
    vn3_mix u_mix (.clk(clk), .en(en), .h(hsh[k]), .unit(unit[k]));
  end

  // trilinear blend: x, then y, then z
  for (genvar j = 0; j < 4; j++) begin : g_lx
    vn3_lerp u_lx (.clk(clk), .en(en), .a(unit[2*j]), .b(unit[2*j+1]),
                   .t(tx6), .y(xl[j]));
  end
  for (genvar j = 0; j < 2; j++) begin : g_ly
    vn3_lerp u_ly (.clk(clk), .en(en), .a(xl[2*j]), .b(xl[2*j+1]),
                   .t(ty7), .y(yl[j]));
  end
  vn3_lerp u_lz (.clk(clk), .en(en), .a(yl[0]), .b(yl[1]), .t(tz8), .y(u));
endmodule

// File: rtl/vn3_chk.sv
// port-level checks for value_noise_3d, bound to the top level
// depends on value_noise_3d
`timescale 1ns / 1ps
module vn3_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped under stall");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed under stall");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output stall");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result after reset");
endmodule

bind value_noise_3d vn3_chk u_vn3_chk (
  .clk(clk), .rst(rst), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

// File: dv/tb_value_noise_3d.sv
// self-checking testbench for the value_noise_3d pipeline
// depends on vn3_pkg and the value_noise_3d rtl
`timescale 1ns / 1ps

// predicts the noise sample of each accepted request and checks results in order
class noise_scoreboard;
  logic [31:0] seed;
  logic [15:0] pending_q[$];
  int          mismatches;

  function new();
    seed       = '0;
    mismatches = 0;
  endfunction

  // floor lattice point and q0.16 fraction of one coordinate
  function automatic void split(input logic [31:0] raw, input int fb,
                                output logic [31:0] lat, output logic [15:0] frac);
    logic [31:0] f;
    lat = $unsigned($signed(raw) >>> fb);
    f   = raw & ((32'd1 << fb) - 1);
    if (fb >= 16) f = f >> (fb - 16);
    else          f = f << (16 - fb);
    frac = f[15:0];
  endfunction

  function automatic logic [15:0] fade(input logic [15:0] f);
    logic [63:0] ff, p, q, g;
    ff = {48'd0, f};
    p  = 64'd6 * ff * ff + (64'd10 << 32) - 64'd15 * ff * 64'd65536;
    q  = p >> 16;
    g  = (ff * ff) >> 16;
    g  = (g * ff) >> 16;
    g  = (g * q) >> 16;
    if (g > 64'd65535) g = 64'd65535;
    return g[15:0];
  endfunction

  function automatic logic [31:0] mix(input logic [31:0] v);
    v = v ^ (v >> 16);
    v = v * vn3_pkg::K_MIX1;
    v = v ^ (v >> 15);
    v = v * vn3_pkg::K_MIX2;
    v = v ^ (v >> 16);
    return v;
  endfunction

  function automatic logic [31:0] blend(input logic [31:0] a, input logic [31:0] b,
                                        input logic [15:0] t);
    logic [63:0] s;
    s = {32'd0, a} * (64'd65536 - t) + {32'd0, b} * {48'd0, t};
    return s[47:16];
  endfunction

  function automatic logic [15:0] noise_at(input logic [95:0] pt);
    logic [31:0] cx, cy, cz, h, u;
    logic [15:0] fx, fy, fz, tx, ty, tz;
    logic [31:0] v[8];
    split(pt[31:0], vn3_pkg::DEF_FRAC_BITS, cx, fx);
    split(pt[63:32], vn3_pkg::DEF_FRAC_BITS, cy, fy);
    split(pt[95:64], vn3_pkg::DEF_FRAC_BITS, cz, fz);
    tx = fade(fx);
    ty = fade(fy);
    tz = fade(fz);
    for (int k = 0; k < 8; k++) begin
      h = seed * vn3_pkg::K_SEED;
      h = h ^ ((cx + k[0]) * vn3_pkg::K_X);
      h = h ^ ((cy + k[1]) * vn3_pkg::K_Y);
      h = h ^ ((cz + k[2]) * vn3_pkg::K_Z);
      v[k] = mix(h) >> 8;
    end
    u = blend(blend(blend(v[0], v[1], tx), blend(v[2], v[3], tx), ty),
              blend(blend(v[4], v[5], tx), blend(v[6], v[7], tx), ty), tz);
    return u[23:8] ^ 16'h8000;
  endfunction

  function void note_request(input logic [95:0] pt);
    pending_q.push_back(noise_at(pt));
  endfunction

  function void check_result(input logic [15:0] got);
    logic [15:0] want;
    if (pending_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", got);
      return;
    end
    want = pending_q.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("noise_value mismatch: expected %h actual %h", want, got);
    end
  endfunction
endclass

module tb_value_noise_3d;
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;         // x_coord, y_coord, z_coord
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;              // noise_value
  logic        noise_seed_we = 1'b0;
  logic [31:0] noise_seed_wdata = '0;

  noise_scoreboard sb = new();
  bit calm_phase  = 1'b0;  // no idling on either side
  int hold_cycles = 0;     // receiver hold-off requested by stimulus

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  value_noise_3d DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .noise_seed_we(noise_seed_we), .noise_seed_wdata(noise_seed_wdata)
  );

  // bookkeeping at the rising edge: accepted requests and results
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_request(s_tdata);
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      m_tready    <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      m_tready <= calm_phase || ($urandom_range(99) >= 8);
    end
  end

  // offer one request and wait for it to be taken; random gaps before it
  task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z);
    while (!calm_phase && $urandom_range(99) < 8) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {z, y, x};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_seed(input logic [31:0] value);
    drain();
    noise_seed_we    <= 1'b1;
    noise_seed_wdata <= value;
    @(negedge clk);
    noise_seed_we <= 1'b0;
    sb.seed = value;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom();
      1: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom())} +
                ($urandom_range(3) << 16);
      2: return {16'($urandom_range(7)) - 16'd4, 16'($urandom())};
      default: return {16'($urandom()), 16'd0};
    endcase
  endfunction

  initial begin
    logic [31:0] seeds[5];
    seeds = '{32'd0, 32'hffffffff, 32'h00000001, 32'h80000000, 32'h0};
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: origin, extremes, negative integers, top-cell wrap, 2d, fraction edges
    send_point(32'h0, 32'h0, 32'h0);
    send_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_point(32'h80000000, 32'h80000000, 32'h80000000);
    send_point(32'hffff0000, 32'hfffe0000, 32'h80000000);
    send_point(32'hffffffff, 32'h0000ffff, 32'h00008000);
    send_point(32'h7fff8000, 32'h12345678, 32'h0);
    send_point(32'h00000001, 32'h00010000, 32'h0);
    send_point(32'h0000ffff, 32'hffff0001, 32'hffffffff);
    send_point(32'haaaaaaaa, 32'h55555555, 32'hcccccccc);
    send_point(32'h55555555, 32'haaaaaaaa, 32'h33333333);

    // random phases across several seeds
    for (int ph = 0; ph < 5; ph++) begin
      write_seed(ph == 4 ? $urandom() : seeds[ph]);
      calm_phase = (ph == 2);
      if (ph == 1) hold_cycles = 60;  // back-pressure fills the pipe
      for (int i = 0; i < 150; i++)
        send_point(rand_coord(), rand_coord(), $urandom_range(4) == 0 ? 32'h0 : rand_coord());
    end
    calm_phase = 1'b0;

    drain();
    if (sb.mismatches == 0 && sb.pending_q.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end
endmodule

// File: files.f
rtl/vn3_pkg.sv
rtl/vn3_mix.sv
rtl/vn3_fade.sv
rtl/vn3_lerp.sv
rtl/value_noise_3d.sv
rtl/vn3_chk.sv
dv/tb_value_noise_3d.sv
